### rtl/ibd_pkg.sv
// ----------------------------------------------------------------------------
// ibd_pkg
// Shared types, constants and pixel math for the icon border desaturate filter.
// ----------------------------------------------------------------------------
package ibd_pkg;

    localparam int PIX_W           = 8;
    localparam int CFG_W           = 13;
    localparam int CFG_IDX_W       = 2;
    localparam int DEFAULT_MAX_DIM = 4096;
    localparam int MIN_DIM         = 8;
    localparam int DIM_RESET       = 64;
    localparam int TOP_ROWS        = 5;
    localparam int SIDE_COLS       = 4;

    localparam logic [PIX_W-1:0] OPAQUE = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    // position of the current pixel within the frame
    typedef struct packed {
        logic border;
        logic last_col;
        logic last_row;
    } pos_flags_t;

    // (min + max) / 2 over the three colour channels
    function automatic logic [PIX_W-1:0] pixel_ave(
        input logic [PIX_W-1:0] r,
        input logic [PIX_W-1:0] g,
        input logic [PIX_W-1:0] b
    );
        logic [PIX_W-1:0] mn;
        logic [PIX_W-1:0] mx;
        logic [PIX_W:0]   sum;
        mn  = (r < g) ? r : g;
        mn  = (mn < b) ? mn : b;
        mx  = (r > g) ? r : g;
        mx  = (mx > b) ? mx : b;
        sum = {1'b0, mn} + {1'b0, mx};
        return sum[PIX_W:1];
    endfunction

    // (ave + c) / 4, never above 127
    function automatic logic [PIX_W-1:0] desat_channel(
        input logic [PIX_W-1:0] ave,
        input logic [PIX_W-1:0] c
    );
        logic [PIX_W:0] sum;
        sum = {1'b0, ave} + {1'b0, c};
        return {1'b0, sum[PIX_W:2]};
    endfunction

endpackage

### rtl/ibd_cfg.sv
// ----------------------------------------------------------------------------
// ibd_cfg
// Frame size registers; keeps the clamped size as the limits the scan uses.
// ----------------------------------------------------------------------------
module ibd_cfg #(
    parameter int MAX_DIM = ibd_pkg::DEFAULT_MAX_DIM,
    parameter int DIM_W   = $clog2(MAX_DIM + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ibd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ibd_pkg::CFG_W-1:0]     cfg_data,
    output logic [DIM_W-1:0]             w_last,
    output logic [DIM_W-1:0]             w_side,
    output logic [DIM_W-1:0]             h_last,
    output logic [DIM_W-1:0]             h_bottom
);

    localparam int CMP_W = (DIM_W > ibd_pkg::CFG_W) ? DIM_W : ibd_pkg::CFG_W;

    localparam logic [DIM_W-1:0] RST_DIM   = DIM_W'(ibd_pkg::DIM_RESET);
    localparam logic [DIM_W-1:0] ONE       = DIM_W'(1);
    localparam logic [DIM_W-1:0] SIDE      = DIM_W'(ibd_pkg::SIDE_COLS);
    localparam logic [DIM_W-1:0] TOP       = DIM_W'(ibd_pkg::TOP_ROWS);

    logic [DIM_W-1:0] w_last_reg,   w_last_next;
    logic [DIM_W-1:0] w_side_reg,   w_side_next;
    logic [DIM_W-1:0] h_last_reg,   h_last_next;
    logic [DIM_W-1:0] h_bottom_reg, h_bottom_next;
    logic [CMP_W-1:0] data_ext;
    logic [DIM_W-1:0] dim_eff;
    logic             wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid;
    assign data_ext  = CMP_W'(cfg_data);

    always_comb
    begin
        if (data_ext < CMP_W'(ibd_pkg::MIN_DIM))
            dim_eff = DIM_W'(ibd_pkg::MIN_DIM);
        else if (data_ext > CMP_W'(MAX_DIM))
            dim_eff = DIM_W'(MAX_DIM);
        else
            dim_eff = data_ext[DIM_W-1:0];
    end

    always_comb
    begin
        w_last_next   = w_last_reg;
        w_side_next   = w_side_reg;
        h_last_next   = h_last_reg;
        h_bottom_next = h_bottom_reg;
        if (wr)
        begin
            case (cfg_index)
                ibd_pkg::REG_FRAME_WIDTH:
                begin
                    w_last_next = dim_eff - ONE;
                    w_side_next = dim_eff - SIDE;
                end
                ibd_pkg::REG_FRAME_HEIGHT:
                begin
                    h_last_next   = dim_eff - ONE;
                    h_bottom_next = dim_eff - TOP;
                end
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg   <= RST_DIM - ONE;
            w_side_reg   <= RST_DIM - SIDE;
            h_last_reg   <= RST_DIM - ONE;
            h_bottom_reg <= RST_DIM - TOP;
        end
        else
        begin
            w_last_reg   <= w_last_next;
            w_side_reg   <= w_side_next;
            h_last_reg   <= h_last_next;
            h_bottom_reg <= h_bottom_next;
        end
    end

    assign w_last   = w_last_reg;
    assign w_side   = w_side_reg;
    assign h_last   = h_last_reg;
    assign h_bottom = h_bottom_reg;

endmodule

### rtl/ibd_scan.sv
// ----------------------------------------------------------------------------
// ibd_scan
// Row and column counters; classifies the current pixel position.
// ----------------------------------------------------------------------------
module ibd_scan #(
    parameter int MAX_DIM = ibd_pkg::DEFAULT_MAX_DIM,
    parameter int DIM_W   = $clog2(MAX_DIM + 1),
    parameter int CNT_W   = $clog2(MAX_DIM)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [DIM_W-1:0]    w_last,
    input  logic [DIM_W-1:0]    w_side,
    input  logic [DIM_W-1:0]    h_last,
    input  logic [DIM_W-1:0]    h_bottom,
    output ibd_pkg::pos_flags_t flags
);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] col_ext;
    logic [DIM_W-1:0] row_ext;
    logic             side_col;

    assign col_ext = DIM_W'(col_reg);
    assign row_ext = DIM_W'(row_reg);

    // column 0 is not a side column
    assign side_col = (col_ext >= DIM_W'(1)) && (col_ext <= DIM_W'(ibd_pkg::SIDE_COLS));

    always_comb
    begin
        flags.last_col = (col_ext >= w_last);
        flags.last_row = (row_ext >= h_last);
        flags.border   = (row_ext < DIM_W'(ibd_pkg::TOP_ROWS))
                      || (row_ext > h_bottom)
                      || side_col
                      || (col_ext >= w_side);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (flags.last_col)
            begin
                col_next = '0;
                row_next = flags.last_row ? '0 : row_reg + CNT_W'(1);
            end
            else
            begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

`ifndef SYNTHESIS
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        advance && flags.last_col && flags.last_row |=> col_reg == '0 && row_reg == '0)
        else $error("counters did not wrap at frame end");

    a_top_rows_border: assert property (@(posedge clk) disable iff (!rst_n)
        row_ext < DIM_W'(ibd_pkg::TOP_ROWS) |-> flags.border)
        else $error("top row pixel not marked as border");

    a_col_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(col_reg) && $stable(row_reg))
        else $error("counters moved without an accepted word");
`endif

endmodule

### rtl/icon_border_desaturate_filter.sv
// ----------------------------------------------------------------------------
// icon_border_desaturate_filter
// Raster-order BGRA pixel filter: the frame border becomes opaque black and
// every inner pixel is darkened and desaturated, (ave + c) / 4 per channel
// with ave = (min + max) / 2 of its colour channels; alpha passes through.
// One pixel is accepted per clock while the result side does not stall; its
// result is registered and appears in the cycle after it is accepted, held
// in the single output register while the result side stalls. The
// border is rows 0 to 4, the last four rows, columns 1 to 4 and the last
// four columns; column 0 is black only in border rows. frame_end marks the
// last pixel of the frame, after which the counters wrap. Frame size writes
// are clamped to 8..MAX_DIM, are always ready, apply from the next accepted
// pixel on, and do not clear the position counters.
// ----------------------------------------------------------------------------
module icon_border_desaturate_filter #(
    parameter int MAX_DIM = ibd_pkg::DEFAULT_MAX_DIM
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          pixel_valid,
    output logic                          pixel_stall,
    input  logic [ibd_pkg::PIX_W-1:0]     in_red,
    input  logic [ibd_pkg::PIX_W-1:0]     in_green,
    input  logic [ibd_pkg::PIX_W-1:0]     in_blue,
    input  logic [ibd_pkg::PIX_W-1:0]     in_alpha,

    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [ibd_pkg::PIX_W-1:0]     out_red,
    output logic [ibd_pkg::PIX_W-1:0]     out_green,
    output logic [ibd_pkg::PIX_W-1:0]     out_blue,
    output logic [ibd_pkg::PIX_W-1:0]     out_alpha,
    output logic                          frame_end,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ibd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ibd_pkg::CFG_W-1:0]     cfg_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(MAX_DIM);

    logic [DIM_W-1:0]    w_last;
    logic [DIM_W-1:0]    w_side;
    logic [DIM_W-1:0]    h_last;
    logic [DIM_W-1:0]    h_bottom;
    ibd_pkg::pos_flags_t flags;
    logic                load;
    logic [ibd_pkg::PIX_W-1:0] ave;

    logic                      valid_reg, valid_next;
    logic [ibd_pkg::PIX_W-1:0] red_reg, red_next;
    logic [ibd_pkg::PIX_W-1:0] green_reg, green_next;
    logic [ibd_pkg::PIX_W-1:0] blue_reg, blue_next;
    logic [ibd_pkg::PIX_W-1:0] alpha_reg, alpha_next;
    logic                      end_reg, end_next;

    ibd_cfg #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .w_last    (w_last),
        .w_side    (w_side),
        .h_last    (h_last),
        .h_bottom  (h_bottom)
    );

    ibd_scan #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W),
        .CNT_W   (CNT_W)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (load),
        .w_last   (w_last),
        .w_side   (w_side),
        .h_last   (h_last),
        .h_bottom (h_bottom),
        .flags    (flags)
    );

    // output word can be replaced whenever it is empty or being taken
    assign pixel_stall = valid_reg && result_stall;
    assign load        = pixel_valid && !pixel_stall;

    assign ave = ibd_pkg::pixel_ave(in_red, in_green, in_blue);

    always_comb
    begin
        valid_next = valid_reg && result_stall;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        alpha_next = alpha_reg;
        end_next   = end_reg;
        if (load)
        begin
            valid_next = 1'b1;
            end_next   = flags.last_col && flags.last_row;
            if (flags.border)
            begin
                red_next   = '0;
                green_next = '0;
                blue_next  = '0;
                alpha_next = ibd_pkg::OPAQUE;
            end
            else
            begin
                red_next   = ibd_pkg::desat_channel(ave, in_red);
                green_next = ibd_pkg::desat_channel(ave, in_green);
                blue_next  = ibd_pkg::desat_channel(ave, in_blue);
                alpha_next = in_alpha;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        alpha_reg <= alpha_next;
        end_reg   <= end_next;
    end

    assign result_valid = valid_reg;
    assign out_red      = red_reg;
    assign out_green    = green_reg;
    assign out_blue     = blue_reg;
    assign out_alpha    = alpha_reg;
    assign frame_end    = end_reg;

`ifndef SYNTHESIS
    a_load_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_stall |=> result_valid)
        else $error("accepted pixel produced no result word");

    a_frame_end_black: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_end |-> out_alpha == ibd_pkg::OPAQUE && out_red == '0
            && out_green == '0 && out_blue == '0)
        else $error("last pixel of frame is not a border pixel");

    a_inner_dark: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> out_red[ibd_pkg::PIX_W-1] == 1'b0
            && out_green[ibd_pkg::PIX_W-1] == 1'b0 && out_blue[ibd_pkg::PIX_W-1] == 1'b0)
        else $error("colour channel above half scale");
`endif

endmodule
